// ===== rtl/core/mpk_pkg.sv =====
// Shared types and constants for the Morse pattern keyer.
// No dependencies; every other file of the block uses this package.
package mpk_pkg;

   localparam int UnitWidth     = 11;
   localparam int DurWidth      = 14;
   localparam int PatternWidth  = 8;
   localparam int ElemWidth     = PatternWidth - 1;
   localparam int CountWidth    = 3;

   localparam logic [UnitWidth-1:0] UnitReset = 11'd60;

   // Input opcodes
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_SPACE = 1'b1;

   // Character in flight: elements still to send, counted down from the top.
   typedef struct packed {
      logic                  space;   // word-space command
      logic [ElemWidth-1:0]  elems;   // pattern bits below the marker
      logic [CountWidth-1:0] count;   // elements left to send
      logic                  gap;     // next result is the gap after a mark
   } stage_type;

   typedef struct packed {
      logic                key_on;
      logic [DurWidth-1:0] duration_ms;
      logic                last;
   } result_type;

endpackage

// ===== rtl/core/mpk_if.sv =====
// Channel interfaces of the Morse pattern keyer: request, response, csr.
// Depends on mpk_pkg for field widths.
interface mpk_req_if;
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic [mpk_pkg::PatternWidth-1:0]  pattern;

   modport source (output valid, opcode, pattern, input ready);
   modport sink   (input valid, opcode, pattern, output ready);
endinterface

interface mpk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          key_on;
   logic [mpk_pkg::DurWidth-1:0]  duration_ms;
   logic                          last;

   modport source (output valid, key_on, duration_ms, last, input ready);
   modport sink   (input valid, key_on, duration_ms, last, output ready);
endinterface

interface mpk_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mpk_pkg::UnitWidth-1:0]  unit_ms;

   modport source (output valid, unit_ms, input ready);
   modport sink   (input valid, unit_ms, output ready);
endinterface

// ===== rtl/core/mpk_unit_reg.sv =====
// Unit length register of the keyer, written through the csr channel.
// Depends on mpk_pkg and mpk_csr_if.
module mpk_unit_reg (
   input  logic                           clock,
   input  logic                           reset,
   mpk_csr_if.sink                        csr,
   output logic [mpk_pkg::UnitWidth-1:0]  unit_ms
);
   import mpk_pkg::*;

   logic [UnitWidth-1:0] unit_ff;
   logic [UnitWidth-1:0] unit_in;

   assign csr.ready = 1'b1;
   assign unit_in   = (csr.valid) ? csr.unit_ms : unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UnitReset;
      end else begin
         unit_ff <= unit_in;
      end
   end

   assign unit_ms = unit_ff;
endmodule

// ===== rtl/core/mpk_load.sv =====
// Decodes an accepted request into the initial character state.
// Depends on mpk_pkg.
module mpk_load (
   input  logic                              opcode,
   input  logic [mpk_pkg::PatternWidth-1:0]  pattern,
   output mpk_pkg::stage_type                stage
);
   import mpk_pkg::*;

   logic [CountWidth-1:0] marker_pos;

   // Leading-one position; no marker or marker in bit 0 leaves no elements.
   always_comb begin
      marker_pos = '0;
      for (int i = 1; i < PatternWidth; i++) begin
         if (pattern[i]) begin
            marker_pos = CountWidth'(i);
         end
      end
   end

   always_comb begin
      stage.space = (opcode == OP_SPACE);
      stage.elems = pattern[ElemWidth-1:0];
      stage.count = marker_pos;
      stage.gap   = 1'b0;
   end
endmodule

// ===== rtl/core/mpk_step_gen.sv =====
// Produces the current result of the character in flight and its next state.
// Depends on mpk_pkg.
module mpk_step_gen (
   input  mpk_pkg::stage_type              stage,
   input  logic [mpk_pkg::UnitWidth-1:0]   unit_ms,
   output mpk_pkg::result_type             result,
   output mpk_pkg::stage_type              stage_next
);
   import mpk_pkg::*;

   logic [DurWidth-1:0]   dur_1;
   logic [DurWidth-1:0]   dur_2;
   logic [DurWidth-1:0]   dur_3;
   logic [DurWidth-1:0]   dur_7;
   logic [CountWidth-1:0] elem_idx;

   assign dur_1    = {{(DurWidth-UnitWidth){1'b0}}, unit_ms};
   assign dur_2    = dur_1 << 1;
   assign dur_3    = dur_2 + dur_1;
   assign dur_7    = (dur_1 << 3) - dur_1;
   assign elem_idx = stage.count - CountWidth'(1);

   always_comb begin
      stage_next = stage;
      result     = '0;
      if (stage.space) begin
         result.duration_ms = dur_7;
         result.last        = 1'b1;
      end else if (stage.count == '0) begin
         result.duration_ms = dur_2;
         result.last        = 1'b1;
      end else if (!stage.gap) begin
         // mark: dash for a one, dot for a zero
         result.key_on      = 1'b1;
         result.duration_ms = stage.elems[elem_idx] ? dur_3 : dur_1;
         stage_next.gap     = 1'b1;
      end else begin
         result.duration_ms = dur_1;
         stage_next.gap     = 1'b0;
         stage_next.count   = elem_idx;
      end
   end
endmodule

// ===== rtl/core/morse_pattern_keyer.sv =====
// Top level of the Morse pattern keyer.
// Depends on mpk_pkg, mpk_if, mpk_unit_reg, mpk_load and mpk_step_gen.
//
// Usage:
//  - req channel: one transfer per item. opcode 0 sends the marker-prefixed
//    pattern (bits below the highest one: 1 = dash, 0 = dot); opcode 1 is a
//    seven-unit word space and pattern is ignored.
//  - rsp channel: one transfer per key event (key_on, duration_ms). last
//    marks the closing key-off of the item.
//  - csr channel: writes unit_ms (ms per unit); always ready. Write only
//    while the block is idle.
// Timing:
//  - An item yields 2*N+1 results (N = elements, up to 7, so 1 to 15),
//    one per cycle unless rsp stalls; the item register steps once per result.
//  - The first result reaches rsp via the item and then the output register.
//  - The next item is taken in the same cycle its predecessor's last result
//    moves to the output register, so items follow back to back.
// Reset: synchronous; clears the item and output valid flags, unit_ms = 60.
// Stall: with rsp.valid high and rsp.ready low the output register holds and
// the item register does not advance; req.ready drops once it is full.
module morse_pattern_keyer (
   input  logic    clock,
   input  logic    reset,
   mpk_req_if.sink   req_bus,
   mpk_rsp_if.source rsp_bus,
   mpk_csr_if.sink   csr_bus
);
   import mpk_pkg::*;

   logic [UnitWidth-1:0] unit_ms;

   stage_type  stage_ff;
   stage_type  stage_in;
   stage_type  stage_load;
   stage_type  stage_step;
   logic       busy_ff;
   logic       busy_in;
   result_type result_ff;
   result_type result_in;
   result_type step_res;
   logic       out_valid_ff;
   logic       out_valid_in;

   logic advance;     // current result moves into the output register
   logic req_take;    // request transfer this cycle

   mpk_unit_reg u_unit_reg (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_bus),
      .unit_ms (unit_ms)
   );

   mpk_load u_load (
      .opcode  (req_bus.opcode),
      .pattern (req_bus.pattern),
      .stage   (stage_load)
   );

   mpk_step_gen u_step_gen (
      .stage      (stage_ff),
      .unit_ms    (unit_ms),
      .result     (step_res),
      .stage_next (stage_step)
   );

   assign advance       = busy_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !busy_ff || (advance && step_res.last);
   assign req_take      = req_bus.valid && req_bus.ready;

   // Item register: load on a transfer, otherwise step on each advance.
   always_comb begin
      stage_in = stage_ff;
      busy_in  = busy_ff;
      if (req_take) begin
         stage_in = stage_load;
         busy_in  = 1'b1;
      end else if (advance) begin
         stage_in = stage_step;
         busy_in  = !step_res.last;
      end
   end

   // Output register: fed by advance, drained by a rsp transfer.
   always_comb begin
      result_in    = result_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         result_in    = step_res;
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff  <= stage_in;
      result_ff <= result_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.key_on      = result_ff.key_on;
   assign rsp_bus.duration_ms = result_ff.duration_ms;
   assign rsp_bus.last        = result_ff.last;

   // an accepted request always occupies the item register next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> busy_ff)
      else $error("item register empty after request transfer");

   // a request is taken over a busy item only as that item finishes
   assert property (@(posedge clock) disable iff (reset)
      (req_take && busy_ff) |-> (advance && step_res.last))
      else $error("request overwrote an unfinished item");

   // every item closes with a key-off
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.last) |-> !result_ff.key_on)
      else $error("last result is a key-on");

   // a key-on result is followed by a key-off of the same item
   assert property (@(posedge clock) disable iff (reset)
      (advance && step_res.key_on) |=> (busy_ff && stage_ff.gap))
      else $error("mark not followed by a gap");
endmodule
